@@ hdl/psf_pkg.sv @@
// Shared types and constants of the 2D spring force unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package psf_pkg;

  localparam int SqrtStages = 33;
  localparam int DivStages = 32;
  localparam logic [1:0] REG_SPRING_CONSTANT = 2'd0;
  localparam logic [1:0] REG_REST_LENGTH = 2'd1;
  localparam logic [1:0] REG_BUNGEE_MODE = 2'd2;
  localparam logic [31:0] SPRING_CONSTANT_RESET = 32'h0001_0000;
  localparam logic [30:0] REST_LENGTH_RESET = 31'h0001_0000;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic [32:0] adx;
    logic [32:0] ady;
    logic [65:0] rad;
  } front_t;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic [32:0] adx;
    logic [32:0] ady;
    logic [32:0] len;
  } root_t;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic        kill;
    logic        zero;
    logic [64:0] nx;
    logic [64:0] ny;
    logic [32:0] len;
  } scaled_t;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic        kill;
    logic        zero;
    logic [31:0] qx;
    logic [31:0] qy;
  } quot_t;

  typedef struct packed {
    logic [31:0] spring_constant;
    logic [30:0] rest_length;
    logic        bungee_mode;
  } cfg_t;

endpackage
`default_nettype wire

@@ hdl/psf_front.sv @@
// Front stages: difference vector, squared components, and their sum.
// Depends on psf_pkg.
`default_nettype none
module psf_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [31:0]    particle_x,
  input  wire logic signed [31:0]    particle_y,
  input  wire logic signed [31:0]    other_x,
  input  wire logic signed [31:0]    other_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output psf_pkg::front_t            out_data
);
  import psf_pkg::*;

  logic [2:0] v;
  logic [3:0] rdy;
  logic s0_sx, s0_sy;
  logic [32:0] s0_adx, s0_ady;
  logic [63:0] sq_x, sq_y;
  logic s1_sx, s1_sy;
  logic [32:0] s1_adx, s1_ady;
  logic [65:0] s1_qx, s1_qy;
  front_t s2;
  logic signed [32:0] dx, dy;

  assign rdy[3] = out_ready;
  assign rdy[0] = !v[0] || rdy[1];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[2] = !v[2] || rdy[3];
  assign in_ready = rdy[0];
  assign out_valid = v[2];
  assign out_data = s2;

  assign dx = 33'(particle_x) - 33'(other_x);
  assign dy = 33'(particle_y) - 33'(other_y);

  assign sq_x = s0_adx[31:0] * s0_adx[31:0];
  assign sq_y = s0_ady[31:0] * s0_ady[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
    end
    if (rdy[0]) begin
      s0_sx <= dx[32];
      s0_sy <= dy[32];
      s0_adx <= dx[32] ? 33'(-dx) : 33'(dx);
      s0_ady <= dy[32] ? 33'(-dy) : 33'(dy);
    end
    if (rdy[1]) begin
      s1_sx <= s0_sx;
      s1_sy <= s0_sy;
      s1_adx <= s0_adx;
      s1_ady <= s0_ady;
      s1_qx <= s0_adx[32] ? {2'b01, 64'd0} : {2'b00, sq_x};
      s1_qy <= s0_ady[32] ? {2'b01, 64'd0} : {2'b00, sq_y};
    end
    if (rdy[2]) begin
      s2.sx <= s1_sx;
      s2.sy <= s1_sy;
      s2.adx <= s1_adx;
      s2.ady <= s1_ady;
      s2.rad <= s1_qx + s1_qy;
    end
  end
endmodule
`default_nettype wire

@@ hdl/psf_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on psf_pkg.
`default_nettype none
module psf_sqrt (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  psf_pkg::front_t in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output psf_pkg::root_t  out_data
);
  import psf_pkg::*;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic [32:0] adx;
    logic [32:0] ady;
    logic [65:0] rad;
    logic [35:0] rem;
    logic [32:0] root;
  } sq_t;

  logic [SqrtStages-1:0] v;
  logic [SqrtStages:0] rdy;
  sq_t st [SqrtStages];
  sq_t nxt [SqrtStages];
  sq_t init;

  assign rdy[SqrtStages] = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = v[SqrtStages-1];
  assign out_data.sx = st[SqrtStages-1].sx;
  assign out_data.sy = st[SqrtStages-1].sy;
  assign out_data.adx = st[SqrtStages-1].adx;
  assign out_data.ady = st[SqrtStages-1].ady;
  assign out_data.len = st[SqrtStages-1].root;

  always_comb begin
    init.sx = in_data.sx;
    init.sy = in_data.sy;
    init.adx = in_data.adx;
    init.ady = in_data.ady;
    init.rad = in_data.rad;
    init.rem = '0;
    init.root = '0;
  end

  for (genvar i = 0; i < SqrtStages; i++) begin : g_stage
    sq_t prev;
    logic [35:0] acc;
    logic [35:0] trial;
    assign prev = (i == 0) ? init : st[(i == 0) ? 0 : i - 1];
    assign rdy[i] = !v[i] || rdy[i+1];
    always_comb begin
      acc = {prev.rem[33:0], prev.rad[65:64]};
      trial = {1'b0, prev.root, 2'b01};
      nxt[i] = prev;
      nxt[i].rad = {prev.rad[63:0], 2'b00};
      if (acc >= trial) begin
        nxt[i].rem = acc - trial;
        nxt[i].root = {prev.root[31:0], 1'b1};
      end else begin
        nxt[i].rem = acc;
        nxt[i].root = {prev.root[31:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
      end
      if (rdy[i]) st[i] <= nxt[i];
    end
  end
endmodule
`default_nettype wire

@@ hdl/psf_scale.sv @@
// Stretch, spring magnitude and per-axis numerators, with bungee and zero flags.
// Depends on psf_pkg.
`default_nettype none
module psf_scale (
  input  wire logic        clk,
  input  wire logic        rst,
  input  psf_pkg::cfg_t    cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  psf_pkg::root_t   in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output psf_pkg::scaled_t out_data
);
  import psf_pkg::*;

  logic [3:0] v;
  logic [4:0] rdy;
  logic [32:0] rest, stretch;
  logic s0_sx, s0_sy, s0_kill, s0_zero, s0_shi;
  logic [32:0] s0_adx, s0_ady, s0_len;
  logic [63:0] s0_p;
  logic s1_sx, s1_sy, s1_kill, s1_zero;
  logic [32:0] s1_adx, s1_ady, s1_len;
  logic [31:0] s1_mag;
  logic [64:0] full;
  logic s2_sx, s2_sy, s2_kill, s2_zero, s2_hx, s2_hy;
  logic [32:0] s2_len;
  logic [31:0] s2_mag;
  logic [63:0] s2_px, s2_py;
  scaled_t s3;

  assign rdy[4] = out_ready;
  assign rdy[0] = !v[0] || rdy[1];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[3] = !v[3] || rdy[4];
  assign in_ready = rdy[0];
  assign out_valid = v[3];
  assign out_data = s3;

  assign rest = {2'b00, cfg.rest_length};
  assign stretch = (in_data.len >= rest) ? in_data.len - rest : rest - in_data.len;
  assign full = {1'b0, s0_p} + (s0_shi ? {1'b0, cfg.spring_constant, 32'd0} : 65'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
    if (rdy[0]) begin
      s0_sx <= in_data.sx;
      s0_sy <= in_data.sy;
      s0_adx <= in_data.adx;
      s0_ady <= in_data.ady;
      s0_len <= in_data.len;
      s0_kill <= cfg.bungee_mode && (in_data.len <= rest);
      s0_zero <= (in_data.len == 33'd0);
      s0_shi <= stretch[32];
      s0_p <= stretch[31:0] * cfg.spring_constant;
    end
    if (rdy[1]) begin
      s1_sx <= s0_sx;
      s1_sy <= s0_sy;
      s1_adx <= s0_adx;
      s1_ady <= s0_ady;
      s1_len <= s0_len;
      s1_kill <= s0_kill;
      s1_zero <= s0_zero;
      s1_mag <= (full[64:48] != 17'd0) ? 32'hFFFF_FFFF : full[47:16];
    end
    if (rdy[2]) begin
      s2_sx <= s1_sx;
      s2_sy <= s1_sy;
      s2_len <= s1_len;
      s2_kill <= s1_kill;
      s2_zero <= s1_zero;
      s2_mag <= s1_mag;
      s2_hx <= s1_adx[32];
      s2_hy <= s1_ady[32];
      s2_px <= s1_mag * s1_adx[31:0];
      s2_py <= s1_mag * s1_ady[31:0];
    end
    if (rdy[3]) begin
      s3.sx <= s2_sx;
      s3.sy <= s2_sy;
      s3.kill <= s2_kill;
      s3.zero <= s2_zero;
      s3.len <= s2_len;
      s3.nx <= {1'b0, s2_px} + (s2_hx ? {1'b0, s2_mag, 32'd0} : 65'd0);
      s3.ny <= {1'b0, s2_py} + (s2_hy ? {1'b0, s2_mag, 32'd0} : 65'd0);
    end
  end
endmodule
`default_nettype wire

@@ hdl/psf_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on psf_pkg.
`default_nettype none
module psf_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  psf_pkg::scaled_t in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output psf_pkg::quot_t   out_data
);
  import psf_pkg::*;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic        kill;
    logic        zero;
    logic [32:0] len;
    logic [31:0] lox;
    logic [31:0] loy;
    logic [32:0] remx;
    logic [32:0] remy;
    logic [31:0] qx;
    logic [31:0] qy;
  } dv_t;

  logic [DivStages-1:0] v;
  logic [DivStages:0] rdy;
  dv_t st [DivStages];
  dv_t nxt [DivStages];
  dv_t init;

  assign rdy[DivStages] = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = v[DivStages-1];
  assign out_data.sx = st[DivStages-1].sx;
  assign out_data.sy = st[DivStages-1].sy;
  assign out_data.kill = st[DivStages-1].kill;
  assign out_data.zero = st[DivStages-1].zero;
  assign out_data.qx = st[DivStages-1].qx;
  assign out_data.qy = st[DivStages-1].qy;

  always_comb begin
    init.sx = in_data.sx;
    init.sy = in_data.sy;
    init.kill = in_data.kill;
    init.zero = in_data.zero;
    init.len = in_data.len;
    init.lox = in_data.nx[31:0];
    init.loy = in_data.ny[31:0];
    init.remx = in_data.nx[64:32];
    init.remy = in_data.ny[64:32];
    init.qx = '0;
    init.qy = '0;
  end

  for (genvar i = 0; i < DivStages; i++) begin : g_stage
    dv_t prev;
    logic [33:0] tx, ty, dl;
    assign prev = (i == 0) ? init : st[(i == 0) ? 0 : i - 1];
    assign rdy[i] = !v[i] || rdy[i+1];
    always_comb begin
      tx = {prev.remx, prev.lox[31]};
      ty = {prev.remy, prev.loy[31]};
      dl = {1'b0, prev.len};
      nxt[i] = prev;
      nxt[i].lox = {prev.lox[30:0], 1'b0};
      nxt[i].loy = {prev.loy[30:0], 1'b0};
      if (tx >= dl) begin
        nxt[i].remx = 33'(tx - dl);
        nxt[i].qx = {prev.qx[30:0], 1'b1};
      end else begin
        nxt[i].remx = tx[32:0];
        nxt[i].qx = {prev.qx[30:0], 1'b0};
      end
      if (ty >= dl) begin
        nxt[i].remy = 33'(ty - dl);
        nxt[i].qy = {prev.qy[30:0], 1'b1};
      end else begin
        nxt[i].remy = ty[32:0];
        nxt[i].qy = {prev.qy[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
      end
      if (rdy[i]) st[i] <= nxt[i];
    end
  end
endmodule
`default_nettype wire

@@ hdl/particle_spring_force_2d_unit.sv @@
// Top level of the 2D spring force unit: register port, pipeline, output stage.
// Depends on psf_pkg, psf_front, psf_sqrt, psf_scale and psf_div.
//
// The unit takes one word per clock while the output is not stalled and
// returns one force word per input word, in order. The depth is set mostly
// by the 33-stage square root and the 32-stage two-lane divider, each of
// which resolves one bit per stage. Registers must be written over the APB
// port only while the pipeline is empty; the block itself does not enforce it.
`default_nettype none
module particle_spring_force_2d_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] particle_x,
  input  wire logic signed [31:0] particle_y,
  input  wire logic signed [31:0] other_x,
  input  wire logic signed [31:0] other_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      force_x,
  output logic signed [31:0]      force_y,
  output logic                    applied
);
  import psf_pkg::*;

  cfg_t cfg;
  front_t fr_data;
  root_t rt_data;
  scaled_t sc_data;
  quot_t qt_data;
  logic fr_valid, fr_ready, rt_valid, rt_ready, sc_valid, sc_ready, qt_valid, qt_ready;
  logic [1:0] reg_index;
  logic [31:0] fx_next, fy_next;

  assign pready = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spring_constant <= SPRING_CONSTANT_RESET;
      cfg.rest_length <= REST_LENGTH_RESET;
      cfg.bungee_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        REG_SPRING_CONSTANT: cfg.spring_constant <= pwdata;
        REG_REST_LENGTH:     cfg.rest_length <= pwdata[30:0];
        REG_BUNGEE_MODE:     cfg.bungee_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SPRING_CONSTANT: prdata = cfg.spring_constant;
      REG_REST_LENGTH:     prdata = {1'b0, cfg.rest_length};
      REG_BUNGEE_MODE:     prdata = {31'd0, cfg.bungee_mode};
      default:             prdata = 32'd0;
    endcase
  end

  psf_front u_front (
    .clk, .rst, .in_valid, .in_ready, .particle_x, .particle_y, .other_x, .other_y,
    .out_valid(fr_valid), .out_ready(fr_ready), .out_data(fr_data)
  );

  psf_sqrt u_sqrt (
    .clk, .rst, .in_valid(fr_valid), .in_ready(fr_ready), .in_data(fr_data),
    .out_valid(rt_valid), .out_ready(rt_ready), .out_data(rt_data)
  );

  psf_scale u_scale (
    .clk, .rst, .cfg, .in_valid(rt_valid), .in_ready(rt_ready), .in_data(rt_data),
    .out_valid(sc_valid), .out_ready(sc_ready), .out_data(sc_data)
  );

  psf_div u_div (
    .clk, .rst, .in_valid(sc_valid), .in_ready(sc_ready), .in_data(sc_data),
    .out_valid(qt_valid), .out_ready(qt_ready), .out_data(qt_data)
  );

  always_comb begin
    if (!qt_data.sx) begin
      fx_next = (qt_data.qx > 32'h8000_0000) ? 32'h8000_0000 : 32'(-qt_data.qx);
    end else begin
      fx_next = (qt_data.qx > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qt_data.qx;
    end
    if (!qt_data.sy) begin
      fy_next = (qt_data.qy > 32'h8000_0000) ? 32'h8000_0000 : 32'(-qt_data.qy);
    end else begin
      fy_next = (qt_data.qy > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qt_data.qy;
    end
    if (qt_data.kill || qt_data.zero) begin
      fx_next = 32'd0;
      fy_next = 32'd0;
    end
  end

  assign qt_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (qt_ready) begin
      out_valid <= qt_valid;
    end
    if (qt_ready) begin
      force_x <= fx_next;
      force_y <= fy_next;
      applied <= !qt_data.kill;
    end
  end

  a_slack_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !applied) |-> (force_x == 32'sd0 && force_y == 32'sd0))
    else $error("suppressed word carries a nonzero force");

  a_reset_cfg: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> (cfg.spring_constant == SPRING_CONSTANT_RESET &&
                    cfg.rest_length == REST_LENGTH_RESET && !cfg.bungee_mode))
    else $error("registers not at reset values after reset");

  a_no_out_after_rst: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !out_valid)
    else $error("output word valid right after reset");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench of the 2D spring force unit: directed and random
// position words, APB register writes, scoreboard with a built-in force predictor.
// Depends on psf_pkg and particle_spring_force_2d_unit.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import psf_pkg::*;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               app;
  } force_word_t;

  class force_scoreboard;
    logic [31:0] k_val;
    logic [30:0] rest_val;
    logic        bungee;
    force_word_t pending[$];
    int          errors;

    function new();
      k_val = SPRING_CONSTANT_RESET;
      rest_val = REST_LENGTH_RESET;
      bungee = 1'b0;
      errors = 0;
    endfunction

    function logic [31:0] component_force(logic signed [32:0] d, logic [31:0] mag,
                                          logic [32:0] len);
      logic [32:0] ad;
      logic [64:0] prod;
      logic [64:0] q;
      ad = d[32] ? -d : d;
      prod = mag * ad;
      q = prod / len;
      if (d > 0) return (q > 65'h8000_0000) ? 32'h8000_0000 : -q[31:0];
      return (q > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function void note_positions(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] ox, logic signed [31:0] oy);
      logic signed [32:0] dx, dy;
      logic [32:0] adx, ady, len, t, stretch;
      logic [66:0] rad;
      logic [66:0] sq;
      logic [64:0] prod;
      logic [48:0] scaled;
      logic [31:0] mag;
      force_word_t w;
      dx = 33'(px) - 33'(ox);
      dy = 33'(py) - 33'(oy);
      adx = dx[32] ? -dx : dx;
      ady = dy[32] ? -dy : dy;
      rad = 67'(adx) * 67'(adx) + 67'(ady) * 67'(ady);
      len = '0;
      for (int b = 32; b >= 0; b--) begin
        t = len | (33'd1 << b);
        sq = 67'(t) * 67'(t);
        if (sq <= rad) len = t;
      end
      w.fx = '0;
      w.fy = '0;
      w.app = 1'b1;
      if (bungee && len <= rest_val) begin
        w.app = 1'b0;
      end else if (len != 0) begin
        stretch = (len >= rest_val) ? len - rest_val : rest_val - len;
        prod = 65'(stretch) * 65'(k_val);
        scaled = prod[64:16];
        mag = (scaled > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
        w.fx = component_force(dx, mag, len);
        w.fy = component_force(dy, mag, len);
      end
      pending.push_back(w);
    endfunction

    function void check_force(logic signed [31:0] fx, logic signed [31:0] fy, logic app);
      force_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected force word fx=%h fy=%h applied=%b", fx, fy, app);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (fx !== w.fx) begin
        $error("force_x expected %h actual %h", w.fx, fx);
        errors++;
      end
      if (fy !== w.fy) begin
        $error("force_y expected %h actual %h", w.fy, fy);
        errors++;
      end
      if (app !== w.app) begin
        $error("applied expected %b actual %b", w.app, app);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] particle_x = '0, particle_y = '0, other_x = '0, other_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] force_x, force_y;
  logic applied;

  force_scoreboard sb;
  bit quiet = 1'b0;
  int cycle_count = 0;

  particle_spring_force_2d_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && out_ready) sb.check_force(force_x, force_y, applied);
    if (cycle_count > 600000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side stalls in random bursts unless the run is in its quiet tail.
  initial begin
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SPRING_CONSTANT: sb.k_val = val;
      REG_REST_LENGTH: sb.rest_val = val[30:0];
      REG_BUNGEE_MODE: sb.bungee = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // The word stays valid after acceptance until the next call or drain() changes it.
  task automatic send_word(logic [31:0] px, logic [31:0] py, logic [31:0] ox,
                           logic [31:0] oy);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    particle_x <= px;
    particle_y <= py;
    other_x <= ox;
    other_y <= oy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_positions(px, py, ox, oy);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      2: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                           : 32'h8000_0000 + $urandom_range(0, 255);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [31:0] ox, oy;
    for (int i = 0; i < n; i++) begin
      ox = rand_coord();
      oy = rand_coord();
      if ($urandom_range(0, 2) == 0)
        send_word(ox + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000,
                  oy + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000, ox, oy);
      else
        send_word(rand_coord(), rand_coord(), ox, oy);
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_word(32'h0003_0000, 32'h0004_0000, 0, 0);
    send_word(0, 0, 32'h0003_0000, 32'h0004_0000);
    send_word(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'h0000_8000, 0, 0, 0);
    send_word(0, 32'hFFFF_0000, 0, 0);
    send_word(32'h0001_0000, 0, 0, 0);
    drain();
    write_reg(REG_SPRING_CONSTANT, 32'hFFFF_FFFF);
    write_reg(REG_REST_LENGTH, 32'h0000_0000);
    send_word(32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
    send_word(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_word(32'h0000_0001, 32'h0000_0001, 0, 0);
    send_word(32'h4000_0000, 32'hC000_0000, 0, 0);
    drain();
    write_reg(REG_REST_LENGTH, 32'h7FFF_FFFF);
    write_reg(REG_BUNGEE_MODE, 32'h1);
    send_word(0, 0, 0, 0);
    send_word(32'h7FFF_FFFF, 0, 0, 0);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    drain();
    write_reg(REG_REST_LENGTH, 32'h0002_0000);
    send_word(32'h0001_0000, 0, 0, 0);
    send_word(32'h0002_0000, 0, 0, 0);
    send_word(32'h0002_0001, 0, 0, 0);
    send_word(0, 0, 0, 0);
    drain();
    write_reg(REG_SPRING_CONSTANT, 32'h0000_0000);
    send_word(32'h0005_0000, 32'h0001_0000, 0, 0);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      write_reg(REG_SPRING_CONSTANT, phase == 0 ? 32'hFFFF_FFFF : phase == 1 ? 32'h0 : $urandom);
      write_reg(REG_REST_LENGTH, phase == 2 ? 32'h7FFF_FFFF : phase == 3 ? 32'h0
                                 : $urandom_range(0, 32'h0004_0000));
      write_reg(REG_BUNGEE_MODE, $urandom);
      if (phase == 6) quiet = 1'b1;
      random_phase(200);
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
hdl/psf_pkg.sv
hdl/psf_front.sv
hdl/psf_sqrt.sv
hdl/psf_scale.sv
hdl/psf_div.sv
hdl/particle_spring_force_2d_unit.sv
tb/tb_top.sv
